/* hdl/ses_pkg.sv */
// Package for the SPI EEPROM access sequencer.
// Holds the beat types, opcode and command codes and the one-hot phase type.
// No dependencies.
package ses_pkg;

  // request/tick opcodes carried in each input beat
  localparam logic [1:0] OP_BEGIN_READ  = 2'd0;
  localparam logic [1:0] OP_BEGIN_WRITE = 2'd1;
  localparam logic [1:0] OP_TICK        = 2'd2;

  // EEPROM instruction bytes
  localparam logic [7:0] INSTR_WREN  = 8'h06;
  localparam logic [7:0] INSTR_RDSR  = 8'h05;
  localparam logic [7:0] INSTR_READ  = 8'h03;
  localparam logic [7:0] INSTR_WRITE = 8'h02;

  // status register bit positions
  localparam int unsigned ST_WIP_BIT = 0;
  localparam int unsigned ST_WEL_BIT = 1;

  localparam logic [7:0] POLL_INTERVAL_RST = 8'd5;

  typedef enum logic [13:0] {
    PH_IDLE             = 14'h0001,
    PH_WREN             = 14'h0002,
    PH_WREN_POLL_START  = 14'h0004,
    PH_WREN_POLL_CHECK  = 14'h0008,
    PH_WRITE_CMD_WAIT   = 14'h0010,
    PH_WRITE_CMD_DATA   = 14'h0020,
    PH_WRITE_DATA_WAIT  = 14'h0040,
    PH_WRITE_POLL_START = 14'h0080,
    PH_WRITE_POLL_WAIT  = 14'h0100,
    PH_WRITE_POLL_CHECK = 14'h0200,
    PH_READ_CMD_DATA    = 14'h0400,
    PH_READ_DATA_WAIT   = 14'h0800,
    PH_DONE             = 14'h1000,
    PH_ERROR            = 14'h2000
  } phase_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [9:0]  mem_address;
    logic [10:0] length;
    logic [15:0] buffer_address;
    logic        link_busy;
    logic [31:0] time_ms;
    logic [7:0]  status_byte;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic        start_transfer;
    logic [7:0]  command_byte;
    logic [9:0]  device_address;
    logic [5:0]  wire_bytes;
    logic [15:0] data_pointer;
    logic [5:0]  data_count;
    logic        copy_out;
    logic        busy_res;
    logic        done_res;
    logic [7:0]  status_seen;
  } out_item_t;

endpackage

/* hdl/ses_ctrl.sv */
// Sequencer state and one-step update logic for the SPI EEPROM sequencer.
// Holds phase, address/length/pointer counters, deadline and poll interval.
// Depends on ses_pkg.
module ses_ctrl #(
  parameter int MEM_BYTES  = 1024,
  parameter int PAGE_BYTES = 32,
  parameter int READ_CHUNK = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  ses_pkg::in_item_t  item_i,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i,
  output ses_pkg::out_item_t res_o
);

  // page offset of a start address: exact reciprocal multiply for 10-bit addresses
  localparam int RECIP_SH = 20;
  localparam int RECIP    = ((1 << RECIP_SH) + PAGE_BYTES - 1) / PAGE_BYTES;
  localparam int OW       = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;

  ses_pkg::phase_e phase_q, phase_d;
  logic [10:0]     cur_q, cur_d;
  logic [10:0]     left_q, left_d;
  logic [15:0]     bptr_q, bptr_d;
  logic [31:0]     dl_q, dl_d;
  logic            done_q, done_d;
  logic [7:0]      stat_q, stat_d;
  logic [7:0]      ival_q;
  logic [9:0]      pgq_q, pgq_d;
  logic [OW-1:0]   off_q, off_d;
  logic            offv_q, offv_d;

  logic        req_ok;
  logic [11:0] end_addr;
  logic        dl_hit;
  logic [31:0] dl_diff;
  logic [OW:0] room;
  logic [OW:0] off_sum;
  logic [10:0] pg_n;
  logic [10:0] rd_n;
  logic [10:0] off_base;

  assign end_addr = {2'b00, item_i.mem_address} + {1'b0, item_i.length};
  assign req_ok   = (phase_q == ses_pkg::PH_IDLE) && (item_i.length != 11'd0)
                    && (32'(end_addr) <= 32'(MEM_BYTES));
  assign dl_diff  = item_i.time_ms - dl_q;
  assign dl_hit   = ~dl_diff[31];

  assign room     = (OW+1)'(PAGE_BYTES) - {1'b0, off_q};
  assign pg_n     = (left_q < 11'(room)) ? left_q : 11'(room);
  assign rd_n     = (left_q < 11'(READ_CHUNK)) ? left_q : 11'(READ_CHUNK);
  assign off_sum  = {1'b0, off_q} + (OW+1)'(pg_n);
  assign off_base = cur_q - 11'(32'(pgq_q) * 32'(PAGE_BYTES));

  always_comb begin
    phase_d = phase_q;
    cur_d   = cur_q;
    left_d  = left_q;
    bptr_d  = bptr_q;
    dl_d    = dl_q;
    done_d  = done_q;
    stat_d  = stat_q;
    pgq_d   = pgq_q;
    off_d   = off_q;
    offv_d  = offv_q;
    res_o   = '0;

    case (item_i.opcode)
      ses_pkg::OP_BEGIN_READ, ses_pkg::OP_BEGIN_WRITE: begin
        if (req_ok) begin
          cur_d   = {1'b0, item_i.mem_address};
          left_d  = item_i.length;
          bptr_d  = item_i.buffer_address;
          done_d  = 1'b0;
          pgq_d   = 10'((32'(item_i.mem_address) * RECIP) >> RECIP_SH);
          offv_d  = 1'b0;
          phase_d = (item_i.opcode == ses_pkg::OP_BEGIN_READ) ?
                    ses_pkg::PH_READ_CMD_DATA : ses_pkg::PH_WREN;
          res_o.accepted = 1'b1;
        end
      end
      ses_pkg::OP_TICK: begin
        unique case (phase_q)
          ses_pkg::PH_IDLE: begin
            phase_d = ses_pkg::PH_IDLE;
          end
          ses_pkg::PH_WREN: begin
            if (!item_i.link_busy) begin
              res_o.start_transfer = 1'b1;
              res_o.command_byte   = ses_pkg::INSTR_WREN;
              res_o.wire_bytes     = 6'd1;
              dl_d    = item_i.time_ms + 32'd1;
              phase_d = ses_pkg::PH_WREN_POLL_START;
              // first page of a request: resolve the page offset once
              if (!offv_q) begin
                off_d  = OW'(off_base);
                offv_d = 1'b1;
              end
            end
          end
          ses_pkg::PH_WREN_POLL_START: begin
            if (!item_i.link_busy) begin
              res_o.start_transfer = 1'b1;
              res_o.command_byte   = ses_pkg::INSTR_RDSR;
              res_o.wire_bytes     = 6'd2;
              phase_d = ses_pkg::PH_WREN_POLL_CHECK;
            end
          end
          ses_pkg::PH_WREN_POLL_CHECK: begin
            if (!item_i.link_busy) begin
              stat_d  = item_i.status_byte;
              phase_d = item_i.status_byte[ses_pkg::ST_WEL_BIT] ?
                        ses_pkg::PH_WRITE_CMD_WAIT : ses_pkg::PH_ERROR;
            end
          end
          ses_pkg::PH_WRITE_CMD_WAIT: begin
            if (dl_hit) phase_d = ses_pkg::PH_WRITE_CMD_DATA;
          end
          ses_pkg::PH_WRITE_CMD_DATA: begin
            if (!item_i.link_busy) begin
              res_o.start_transfer = 1'b1;
              res_o.command_byte   = ses_pkg::INSTR_WRITE;
              res_o.device_address = cur_q[9:0];
              res_o.wire_bytes     = 6'(11'd3 + pg_n);
              res_o.data_pointer   = bptr_q;
              res_o.data_count     = 6'(pg_n);
              left_d  = left_q - pg_n;
              cur_d   = cur_q + pg_n;
              bptr_d  = bptr_q + 16'(pg_n);
              // wrap the offset at the page boundary
              off_d   = (off_sum == (OW+1)'(PAGE_BYTES)) ? '0 : OW'(off_sum);
              phase_d = ses_pkg::PH_WRITE_DATA_WAIT;
            end
          end
          ses_pkg::PH_WRITE_DATA_WAIT: begin
            if (!item_i.link_busy) begin
              dl_d    = item_i.time_ms + 32'(ival_q);
              phase_d = ses_pkg::PH_WRITE_POLL_START;
            end
          end
          ses_pkg::PH_WRITE_POLL_START: begin
            if (!item_i.link_busy) begin
              dl_d    = item_i.time_ms + 32'(ival_q);
              phase_d = ses_pkg::PH_WRITE_POLL_WAIT;
            end
          end
          ses_pkg::PH_WRITE_POLL_WAIT: begin
            if (dl_hit) begin
              res_o.start_transfer = 1'b1;
              res_o.command_byte   = ses_pkg::INSTR_RDSR;
              res_o.wire_bytes     = 6'd2;
              phase_d = ses_pkg::PH_WRITE_POLL_CHECK;
            end
          end
          ses_pkg::PH_WRITE_POLL_CHECK: begin
            if (!item_i.link_busy) begin
              stat_d = item_i.status_byte;
              if (item_i.status_byte[ses_pkg::ST_WIP_BIT]) begin
                phase_d = ses_pkg::PH_WRITE_POLL_START;
              end else begin
                phase_d = (left_q == 11'd0) ? ses_pkg::PH_DONE : ses_pkg::PH_WREN;
              end
            end
          end
          ses_pkg::PH_READ_CMD_DATA: begin
            if (!item_i.link_busy) begin
              res_o.start_transfer = 1'b1;
              res_o.command_byte   = ses_pkg::INSTR_READ;
              res_o.device_address = cur_q[9:0];
              res_o.wire_bytes     = 6'(11'd3 + rd_n);
              res_o.data_count     = 6'(rd_n);
              phase_d = ses_pkg::PH_READ_DATA_WAIT;
            end
          end
          ses_pkg::PH_READ_DATA_WAIT: begin
            if (!item_i.link_busy) begin
              res_o.copy_out     = 1'b1;
              res_o.data_pointer = bptr_q;
              res_o.data_count   = 6'(rd_n);
              left_d  = left_q - rd_n;
              cur_d   = cur_q + rd_n;
              bptr_d  = bptr_q + 16'(rd_n);
              phase_d = (left_q == rd_n) ? ses_pkg::PH_DONE : ses_pkg::PH_READ_CMD_DATA;
            end
          end
          ses_pkg::PH_DONE: begin
            done_d  = 1'b1;
            phase_d = ses_pkg::PH_IDLE;
          end
          ses_pkg::PH_ERROR: begin
            phase_d = ses_pkg::PH_IDLE;
          end
          default: begin
            phase_d = ses_pkg::PH_IDLE;
          end
        endcase
      end
      default: begin
        phase_d = phase_q;
      end
    endcase

    res_o.busy_res    = (phase_d != ses_pkg::PH_IDLE);
    res_o.done_res    = done_d;
    res_o.status_seen = stat_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ses_pkg::PH_IDLE;
      cur_q   <= '0;
      left_q  <= '0;
      bptr_q  <= '0;
      dl_q    <= '0;
      done_q  <= 1'b0;
      stat_q  <= '0;
      pgq_q   <= '0;
      off_q   <= '0;
      offv_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      cur_q   <= cur_d;
      left_q  <= left_d;
      bptr_q  <= bptr_d;
      dl_q    <= dl_d;
      done_q  <= done_d;
      stat_q  <= stat_d;
      pgq_q   <= pgq_d;
      off_q   <= off_d;
      offv_q  <= offv_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ival_q <= ses_pkg::POLL_INTERVAL_RST;
    end else if (cfg_we_i) begin
      ival_q <= cfg_wdata_i;
    end
  end

endmodule

/* hdl/spi_eeprom_access_sequencer.sv */
// Top level of the SPI EEPROM access sequencer: input register, step logic, result register.
// Depends on ses_pkg and ses_ctrl.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i) carries one beat per request
//   or tick: begin read, begin write, or tick. A request is accepted only when the
//   sequencer is idle, the length is non-zero and the range fits the memory.
//   Every input beat produces exactly one result beat on the output channel
//   (out_valid_o / out_stall_i / out_item_o): a transfer or copy descriptor plus
//   busy, done and last status.
//   Throughput: one beat per clock while no result is stalled. Each beat is one state step in ses_ctrl.
//   Path: an accepted beat is stored in the input register, then stepped by
//   ses_ctrl and written into the result register, where its result is valid.
//   Stall: while out_stall_i holds a waiting result, the input register holds its
//   beat and in_stall_o rises once the input register is full; nothing is dropped.
//   Reset: both registers empty, sequencer idle, poll interval 5 ms.
//   cfg_we_i / cfg_wdata_i write the poll interval; write only while idle.
module spi_eeprom_access_sequencer #(
  parameter int MEM_BYTES  = 1024,
  parameter int PAGE_BYTES = 32,
  parameter int READ_CHUNK = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ses_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ses_pkg::out_item_t out_item_o,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i
);

  logic               in_vld_q, in_vld_d;
  ses_pkg::in_item_t  in_q;
  logic               out_vld_q, out_vld_d;
  ses_pkg::out_item_t out_q;
  ses_pkg::out_item_t step_res;
  logic               adv;
  logic               step;
  logic               take;

  // result register free or draining this cycle
  assign adv  = ~out_vld_q | ~out_stall_i;
  assign step = in_vld_q & adv;
  assign in_stall_o = in_vld_q & ~adv;
  assign take = in_valid_i & ~in_stall_o;

  assign in_vld_d  = take | (in_vld_q & ~adv);
  assign out_vld_d = step | (out_vld_q & out_stall_i);

  ses_ctrl #(
    .MEM_BYTES (MEM_BYTES),
    .PAGE_BYTES(PAGE_BYTES),
    .READ_CHUNK(READ_CHUNK)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .item_i     (in_q),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .res_o      (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) in_q <= in_item_i;
    if (step) out_q <= step_res;
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule

/* hdl/ses_checker.sv */
// Port-level checker for the SPI EEPROM access sequencer, bound to the top level.
// Depends on ses_pkg and spi_eeprom_access_sequencer.
module ses_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input ses_pkg::out_item_t out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result beat changed or dropped");

  a_in_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");

  a_accept_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.accepted |->
      !out_item_o.start_transfer && !out_item_o.copy_out && out_item_o.busy_res
      && !out_item_o.done_res)
    else $error("accepted request carried a descriptor");

  a_cmd_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.start_transfer |->
      (out_item_o.command_byte == ses_pkg::INSTR_WREN && out_item_o.wire_bytes == 6'd1)
      || (out_item_o.command_byte == ses_pkg::INSTR_RDSR && out_item_o.wire_bytes == 6'd2)
      || out_item_o.command_byte == ses_pkg::INSTR_READ
      || out_item_o.command_byte == ses_pkg::INSTR_WRITE)
    else $error("transfer descriptor with bad command or length");

  a_copy_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.copy_out |->
      !out_item_o.start_transfer && out_item_o.command_byte == 8'h00)
    else $error("copy descriptor overlaps a transfer");

endmodule

bind spi_eeprom_access_sequencer ses_checker u_ses_checker (.*);
